// ----- hw/rtl/block_map_allocator_core_assert.svh -----
// Assertion macros shared by the block map allocator RTL.
// Needs signals named clock and reset in the including module.
`ifndef BLOCK_MAP_ALLOCATOR_CORE_ASSERT_SVH
`define BLOCK_MAP_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BMA_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define BMA_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/bma_pkg.sv -----
// Shared types and constants of the block map allocator.
// No dependencies; used by block_map_allocator_core, the checker and the testbench.
package bma_pkg;

   localparam int OP_W      = 2;
   localparam int POOL_W    = 2;
   localparam int SIZE_W    = 22;
   localparam int FOFF_W    = 16;
   localparam int STAT_W    = 2;
   localparam int OFF_W     = 15;
   localparam int PCT_W     = 7;
   localparam int ENTRY_W   = 11;
   localparam int CFG_W     = 11;
   localparam int NUM_CFG   = 3;
   localparam int CSR_AW    = 4;
   localparam int PDATA_W   = 32;
   localparam int PCT_SCALE = 100;

   localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

   // Request opcodes.
   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OP_W-1:0] OP_USAGE = 2'd2;

   // Result status codes.
   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_FAIL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [POOL_W-1:0] pool;
      logic [SIZE_W-1:0] size_bytes;
      logic [FOFF_W-1:0] free_offset;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [OFF_W-1:0]  byte_offset;
      logic [PCT_W-1:0]  usage_percent;
   } rsp_type;

endpackage

// ----- hw/rtl/bma_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Uses block_map_allocator_core_assert.svh; no package needed.
`include "block_map_allocator_core_assert.svh"

module bma_div #(
   parameter int DW = 23,
   parameter int VW = 11
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient,
   output logic [VW-1:0] remainder
);

   localparam int CNTW = $clog2(DW + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]   quo_ff, quo_in;
   logic [VW-1:0]   rem_ff, rem_in;
   logic [VW-1:0]   div_ff, div_in;
   logic [VW:0]     shift_rem;
   logic [VW:0]     diff;

   assign shift_rem = {rem_ff, quo_ff[DW-1]};
   assign diff      = shift_rem - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNTW'(DW);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         // subtract when the shifted remainder covers the divisor
         if (shift_rem >= {1'b0, div_ff}) begin
            rem_in = diff[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = shift_rem[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   `BMA_ASSERT_IMP(a_start_idle, start, !busy_ff, "divider started while busy")
   `BMA_ASSERT_IMP(a_rem_below, busy_ff && (div_ff != '0), rem_ff < div_ff, "remainder not reduced")
   `BMA_ASSERT_NXT(a_start_load, start, busy_ff && (cnt_ff == CNTW'(DW)), "divider did not load")

endmodule

// ----- hw/rtl/block_map_allocator_core.sv -----
// Block map allocator top level: request/result channels, APB registers, block map.
// Depends on bma_pkg, bma_div and block_map_allocator_core_assert.svh.
//
// Usage:
//  - req channel (valid/ready) carries one request: allocate, free or usage query
//    on one pool. rsp channel (valid/ready) returns exactly one result per request.
//  - APB port holds the block count of pools zero to two at byte addresses 0, 4, 8.
//    Write it only while the block is idle. Counts above MAP_BLOCKS act as MAP_BLOCKS.
//  - Allocate rounds the size up to blocks with a constant reciprocal, scans the map
//    from the top down for a free run and marks each block of the run with its length.
//    Free reads the entry at the offset and clears its run, clamped at the pool end.
//    Usage counts the used entries, then divides for the percentage (DW = divider
//    width, 17 at defaults). Zero size, an empty pool or an undefined opcode go
//    straight to the result.
//  - The map memory has one write and one read port, each handling one entry per
//    cycle; only the usage percentage uses the one-bit-per-cycle divider.
//  - Only one request is in flight; req_ready is high while idle, even when a
//    finished result still waits in the output register.
//  - If the receiver stalls, the next result waits until the output register is
//    taken; no result is dropped.
//  - After reset the map memory is swept to zero, one entry per cycle, over all
//    POOLS * MAP_BLOCKS entries (3072 by default) before the first request transfer.
`include "block_map_allocator_core_assert.svh"

module block_map_allocator_core #(
   parameter int MAP_BLOCKS  = 1024,
   parameter int BLOCK_BYTES = 32,
   parameter int POOLS       = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  bma_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bma_pkg::rsp_type              rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bma_pkg::CSR_AW-1:0]    paddr,
   input  logic [bma_pkg::PDATA_W-1:0]   pwdata,
   output logic [bma_pkg::PDATA_W-1:0]   prdata,
   output logic                          pready
);

   import bma_pkg::*;

   localparam int DEPTH = POOLS * MAP_BLOCKS;
   localparam int AW    = $clog2(DEPTH);
   localparam int IW    = $clog2(MAP_BLOCKS);
   localparam int CW    = $clog2(MAP_BLOCKS + 1);
   localparam int PW    = $clog2(MAP_BLOCKS * PCT_SCALE + 1);
   localparam int DW    = PW;
   localparam int VW    = CW;
   localparam int QN    = SIZE_W + 1;
   localparam int BL    = $clog2(BLOCK_BYTES);
   localparam int RW    = QN + 1;
   localparam int PRW   = QN + RW;
   localparam longint unsigned RECIP =
      ((64'd1 << (QN + BL)) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);
   localparam int RIW   = CSR_AW - 2;

   typedef enum logic [11:0] {
      S_CLEAR = 12'b0000_0000_0001,
      S_IDLE  = 12'b0000_0000_0010,
      S_DIV   = 12'b0000_0000_0100,
      S_SCAN  = 12'b0000_0000_1000,
      S_MARK  = 12'b0000_0001_0000,
      S_MUL   = 12'b0000_0010_0000,
      S_FREAD = 12'b0000_0100_0000,
      S_FWAIT = 12'b0000_1000_0000,
      S_FCLR  = 12'b0001_0000_0000,
      S_COUNT = 12'b0010_0000_0000,
      S_PDIV  = 12'b0100_0000_0000,
      S_DONE  = 12'b1000_0000_0000
   } state_type;

   // Control registers
   state_type       state_ff, state_in;
   logic [AW-1:0]   clr_ff, clr_in;
   logic            iss_more_ff, iss_more_in;
   logic            rd_vld_ff;
   logic            rsp_valid_ff;
   logic [CFG_W-1:0] cfg_ff [NUM_CFG];

   // Per-request working registers
   logic [OP_W-1:0] op_ff, op_in;
   logic [CW-1:0]   nblk_ff, nblk_in;
   logic [AW-1:0]   base_ff, base_in;
   logic [CW-1:0]   need_ff, need_in;
   logic [CW-1:0]   run_ff, run_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [CW-1:0]   used_ff, used_in;
   logic [IW-1:0]   iss_ff, iss_in;
   logic [IW-1:0]   chk_ff, chk_in;
   logic [IW-1:0]   idx_ff, idx_in;
   logic [IW-1:0]   fnd_ff, fnd_in;
   logic [IW-1:0]   wr_idx_ff, wr_idx_in;
   logic [QN-1:0]   blk_dvd_ff, blk_dvd_in;
   rsp_type         res_ff, res_in;
   rsp_type         rsp_ff;

   // Map memory
   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;

   // Divider hookup
   logic            div_start;
   logic [DW-1:0]   div_dvd;
   logic [VW-1:0]   div_dvs;
   logic            div_done;
   logic [DW-1:0]   div_quo;
   logic [VW-1:0]   div_rem;

   // Helpers
   logic [CFG_W-1:0] cfg_raw;
   logic [CW-1:0]    pool_blocks;
   logic [PRW-1:0]   blk_prod;
   logic [QN-1:0]    blk_quo;
   logic [CW-1:0]    run_nx;
   logic [CW-1:0]    used_nx;
   logic [CW-1:0]    tail_blocks;
   logic [CW-1:0]    free_cnt;
   logic             rsp_load;
   logic             csr_wr;
   logic [RIW-1:0]   csr_idx;

   bma_div #(
      .DW (DW),
      .VW (VW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // ------------------------------------------------------------------
   // APB registers
   // ------------------------------------------------------------------
   assign pready  = 1'b1;
   assign csr_idx = paddr[CSR_AW-1:2];
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_CFG; p++) begin
            cfg_ff[p] <= CFG_RESET;
         end
      end else if (csr_wr) begin
         // writes past the last register are dropped
         for (int p = 0; p < NUM_CFG; p++) begin
            if (csr_idx == RIW'(p)) begin
               cfg_ff[p] <= pwdata[CFG_W-1:0];
            end
         end
      end
   end

   always_comb begin
      prdata = '0;
      for (int p = 0; p < NUM_CFG; p++) begin
         if (csr_idx == RIW'(p)) begin
            prdata = PDATA_W'(cfg_ff[p]);
         end
      end
   end

   // ------------------------------------------------------------------
   // Effective block count of the requested pool
   // ------------------------------------------------------------------
   always_comb begin
      cfg_raw = '0;
      for (int p = 0; p < NUM_CFG; p++) begin
         if (req_data.pool == POOL_W'(p)) begin
            cfg_raw = cfg_ff[p];
         end
      end
      priority if (32'(req_data.pool) >= POOLS) begin
         pool_blocks = '0;
      end else if (32'(req_data.pool) >= NUM_CFG) begin
         pool_blocks = CW'(MAP_BLOCKS);
      end else if (32'(cfg_raw) > MAP_BLOCKS) begin
         pool_blocks = CW'(MAP_BLOCKS);
      end else begin
         pool_blocks = CW'(cfg_raw);
      end
   end

   // Divide by the block size with a constant reciprocal; exact for any QN-bit value.
   assign blk_prod    = PRW'(blk_dvd_ff) * PRW'(RECIP);
   assign blk_quo     = QN'(blk_prod >> (QN + BL));

   assign run_nx      = (rd_data_ff == '0) ? (run_ff + 1'b1) : '0;
   assign used_nx     = used_ff + CW'(rd_data_ff != '0);
   assign tail_blocks = nblk_ff - CW'(idx_ff);
   assign free_cnt    = (32'(rd_data_ff) > 32'(tail_blocks)) ? tail_blocks
                                                              : CW'(rd_data_ff);

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      iss_more_in = iss_more_ff;
      op_in       = op_ff;
      nblk_in     = nblk_ff;
      base_in     = base_ff;
      need_in     = need_ff;
      run_in      = run_ff;
      cnt_in      = cnt_ff;
      used_in     = used_ff;
      iss_in      = iss_ff;
      chk_in      = chk_ff;
      idx_in      = idx_ff;
      fnd_in      = fnd_ff;
      wr_idx_in   = wr_idx_ff;
      blk_dvd_in  = blk_dvd_ff;
      res_in      = res_ff;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = '0;
      rd_en       = 1'b0;
      rd_addr     = '0;
      div_start   = 1'b0;
      div_dvd     = '0;
      div_dvs     = '0;

      unique case (state_ff)
         S_CLEAR: begin
            // sweep the map to all free
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               op_in   = req_data.op;
               nblk_in = pool_blocks;
               base_in = AW'(32'(req_data.pool) * MAP_BLOCKS);
               res_in  = '0;
               unique case (req_data.op)
                  OP_ALLOC: begin
                     res_in.status = ST_FAIL;
                     if ((req_data.size_bytes == '0) || (pool_blocks == '0)) begin
                        state_in = S_DONE;
                     end else begin
                        // round bytes up to blocks
                        blk_dvd_in = QN'(req_data.size_bytes) + QN'(BLOCK_BYTES - 1);
                        state_in   = S_DIV;
                     end
                  end
                  OP_FREE: begin
                     if (pool_blocks == '0) begin
                        res_in.status = ST_RANGE;
                        state_in      = S_DONE;
                     end else begin
                        blk_dvd_in = QN'(req_data.free_offset);
                        state_in   = S_DIV;
                     end
                  end
                  OP_USAGE: begin
                     if (pool_blocks == '0) begin
                        state_in = S_DONE;
                     end else begin
                        iss_in      = '0;
                        iss_more_in = 1'b1;
                        used_in     = '0;
                        state_in    = S_COUNT;
                     end
                  end
                  default: begin
                     // undefined opcode: all-zero result, map untouched
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_DIV: begin
            if (op_ff == OP_ALLOC) begin
               if (blk_quo > QN'(nblk_ff)) begin
                  state_in = S_DONE;
               end else begin
                  need_in     = CW'(blk_quo);
                  run_in      = '0;
                  iss_in      = IW'(nblk_ff - 1'b1);
                  iss_more_in = 1'b1;
                  state_in    = S_SCAN;
               end
            end else begin
               if (blk_quo >= QN'(nblk_ff)) begin
                  res_in.status = ST_RANGE;
                  state_in      = S_DONE;
               end else begin
                  idx_in   = IW'(blk_quo);
                  state_in = S_FREAD;
               end
            end
         end

         S_SCAN: begin
            // issue reads top down; check the entry read in the previous cycle
            if (iss_more_ff) begin
               rd_en   = 1'b1;
               rd_addr = base_ff + AW'(iss_ff);
               chk_in  = iss_ff;
               if (iss_ff == '0) begin
                  iss_more_in = 1'b0;
               end else begin
                  iss_in = iss_ff - 1'b1;
               end
            end
            if (rd_vld_ff) begin
               run_in = run_nx;
               if (run_nx == need_ff) begin
                  fnd_in      = chk_ff;
                  wr_idx_in   = chk_ff;
                  cnt_in      = need_ff;
                  iss_more_in = 1'b0;
                  state_in    = S_MARK;
               end else if (chk_ff == '0) begin
                  state_in = S_DONE;
               end
            end
         end

         S_MARK: begin
            wr_en     = 1'b1;
            wr_addr   = base_ff + AW'(wr_idx_ff);
            wr_data   = ENTRY_W'(need_ff);
            wr_idx_in = wr_idx_ff + 1'b1;
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               state_in = S_MUL;
            end
         end

         S_MUL: begin
            res_in.status      = ST_DONE;
            res_in.byte_offset = OFF_W'(32'(fnd_ff) * BLOCK_BYTES);
            state_in           = S_DONE;
         end

         S_FREAD: begin
            rd_en    = 1'b1;
            rd_addr  = base_ff + AW'(idx_ff);
            state_in = S_FWAIT;
         end

         S_FWAIT: begin
            // run length at the block, clamped at the pool end
            if (free_cnt == '0) begin
               state_in = S_DONE;
            end else begin
               wr_idx_in = idx_ff;
               cnt_in    = free_cnt;
               state_in  = S_FCLR;
            end
         end

         S_FCLR: begin
            wr_en     = 1'b1;
            wr_addr   = base_ff + AW'(wr_idx_ff);
            wr_idx_in = wr_idx_ff + 1'b1;
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               state_in = S_DONE;
            end
         end

         S_COUNT: begin
            if (iss_more_ff) begin
               rd_en   = 1'b1;
               rd_addr = base_ff + AW'(iss_ff);
               chk_in  = iss_ff;
               if (iss_ff == IW'(nblk_ff - 1'b1)) begin
                  iss_more_in = 1'b0;
               end else begin
                  iss_in = iss_ff + 1'b1;
               end
            end
            if (rd_vld_ff) begin
               used_in = used_nx;
               if (chk_ff == IW'(nblk_ff - 1'b1)) begin
                  div_start = 1'b1;
                  div_dvd   = DW'(32'(used_nx) * PCT_SCALE);
                  div_dvs   = VW'(nblk_ff);
                  state_in  = S_PDIV;
               end
            end
         end

         S_PDIV: begin
            if (div_done) begin
               res_in.usage_percent = PCT_W'(div_quo);
               state_in             = S_DONE;
            end
         end

         S_DONE: begin
            // hold until the output register is free
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_ff      <= '0;
         iss_more_ff <= 1'b0;
         rd_vld_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         iss_more_ff <= iss_more_in;
         rd_vld_ff   <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      nblk_ff    <= nblk_in;
      base_ff    <= base_in;
      need_ff    <= need_in;
      run_ff     <= run_in;
      cnt_ff     <= cnt_in;
      used_ff    <= used_in;
      iss_ff     <= iss_in;
      chk_ff     <= chk_in;
      idx_ff     <= idx_in;
      fnd_ff     <= fnd_in;
      wr_idx_ff  <= wr_idx_in;
      blk_dvd_ff <= blk_dvd_in;
      res_ff     <= res_in;
   end

   // Map memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // ------------------------------------------------------------------
   // Output register: advance on load, drop valid after the transfer
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `BMA_ASSERT_IMP(a_wr_in_map, wr_en, 32'(wr_addr) < DEPTH, "map write outside the map")
   `BMA_ASSERT_IMP(a_scan_run, state_ff == S_SCAN, run_ff < need_ff, "free run passed its length")
   `BMA_ASSERT_IMP(a_run_cnt, (state_ff == S_MARK) || (state_ff == S_FCLR), cnt_ff != '0, "empty run write")
   `BMA_ASSERT_IMP(a_fail_off, rsp_valid_ff && (rsp_ff.status != ST_DONE), rsp_ff.byte_offset == '0, "offset on failed result")
   `BMA_ASSERT_IMP(a_pct_max, rsp_valid_ff, rsp_ff.usage_percent <= PCT_W'(PCT_SCALE), "usage above full scale")

endmodule

// ----- sim/block_map_allocator_checker.sv -----
// Result checker for the block map allocator: follows register writes and request
// transfers, predicts each result and compares it with what the result channel delivers.
// Depends on bma_pkg.
module block_map_allocator_checker #(
   parameter int MAP_BLOCKS  = 1024,
   parameter int BLOCK_BYTES = 32,
   parameter int POOLS       = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  bma_pkg::req_type              req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  bma_pkg::rsp_type              rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bma_pkg::CSR_AW-1:0]    paddr,
   input  logic [bma_pkg::PDATA_W-1:0]   pwdata,
   input  logic                          pready,
   output int unsigned                   mismatches,
   output int unsigned                   pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import bma_pkg::*;

   logic [ENTRY_W-1:0] run_len [POOLS][MAP_BLOCKS];
   logic [CFG_W-1:0]   pool_size [NUM_CFG];
   rsp_type            result_q [$];

   // Blocks a pool manages; a pool number of POOLS or more is empty.
   function automatic int unsigned pool_blocks(input int unsigned p);
      if (p >= POOLS) return 0;
      if (p >= NUM_CFG) return MAP_BLOCKS;
      return (pool_size[p] > MAP_BLOCKS) ? MAP_BLOCKS : pool_size[p];
   endfunction

   // Apply one request to the map copy and return the result it must give.
   function automatic rsp_type apply_request(input req_type r);
      rsp_type     res;
      int unsigned p, nblk, need, run, idx, cnt, used, k;
      int          i;
      bit          found;
      res   = '0;
      p     = r.pool;
      nblk  = pool_blocks(p);
      found = 1'b0;
      case (r.op)
         OP_ALLOC: begin
            res.status = ST_FAIL;
            need = (int'(r.size_bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
            if (r.size_bytes != 0 && nblk != 0 && need <= nblk) begin
               run = 0;
               // first fit, top of the pool downward
               for (i = nblk - 1; i >= 0 && !found; i--) begin
                  run = (run_len[p][i] == '0) ? run + 1 : 0;
                  if (run == need) begin
                     found = 1'b1;
                     for (k = 0; k < need; k++) run_len[p][i + k] = ENTRY_W'(need);
                     res.status      = ST_DONE;
                     res.byte_offset = OFF_W'(i * BLOCK_BYTES);
                  end
               end
            end
         end
         OP_FREE: begin
            idx = r.free_offset / BLOCK_BYTES;
            if (idx >= nblk) begin
               res.status = ST_RANGE;
            end else begin
               cnt = run_len[p][idx];
               if (cnt > nblk - idx) cnt = nblk - idx;
               for (k = 0; k < cnt; k++) run_len[p][idx + k] = '0;
               res.status = ST_DONE;
            end
         end
         OP_USAGE: begin
            res.status = ST_DONE;
            if (nblk != 0) begin
               used = 0;
               for (k = 0; k < nblk; k++) if (run_len[p][k] != '0) used++;
               res.usage_percent = PCT_W'(used * PCT_SCALE / nblk);
            end
         end
         default: res = '0;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type     want;
      int unsigned widx;
      if (reset) begin
         for (int p = 0; p < POOLS; p++)
            for (int b = 0; b < MAP_BLOCKS; b++) run_len[p][b] = '0;
         for (int c = 0; c < NUM_CFG; c++) pool_size[c] = CFG_RESET;
         result_q.delete();
         mismatches = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            widx = paddr >> 2;
            if (widx < NUM_CFG) pool_size[widx] = pwdata[CFG_W-1:0];
         end
         // results first: a result never belongs to a request taken at the same edge
         if (rsp_valid && rsp_ready) begin
            if (result_q.size() == 0) begin
               $error("unexpected result: status %0d offset %0d usage %0d",
                      rsp_data.status, rsp_data.byte_offset, rsp_data.usage_percent);
               mismatches++;
            end else begin
               want = result_q.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  mismatches++;
               end
               if (rsp_data.byte_offset !== want.byte_offset) begin
                  $error("byte_offset: expected %0d, got %0d",
                         want.byte_offset, rsp_data.byte_offset);
                  mismatches++;
               end
               if (rsp_data.usage_percent !== want.usage_percent) begin
                  $error("usage_percent: expected %0d, got %0d",
                         want.usage_percent, rsp_data.usage_percent);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) result_q.push_back(apply_request(req_data));
      end
      pending = result_q.size();
   end

endmodule

// ----- sim/block_map_allocator_core_test.sv -----
// Testbench top for block_map_allocator_core: clock, reset, request and register stimulus,
// result-side back-pressure, watchdog and verdict.
// Depends on bma_pkg, the allocator RTL and block_map_allocator_checker.
module block_map_allocator_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import bma_pkg::*;

   localparam int MAP_BLOCKS  = 1024;
   localparam int BLOCK_BYTES = 32;
   localparam int POOLS       = 3;

   // Longest correct stretch without a transfer is the clearing sweep after reset
   // or one full allocate on a 1024-block pool behind a long receiver hold-off;
   // take that several times over.
   localparam int WATCHDOG_LIMIT = 20000;
   // After the last result, wait out a worst-case item to catch stray results.
   localparam int TAIL_CYCLES    = 2200;
   localparam int RANDOM_ITEMS   = 54;
   localparam int NUM_PHASES     = 5;
   localparam int HOLD_CYCLES    = 600;

   // Opcode the block leaves undefined.
   localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data  = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                psel      = 1'b0;
   logic                penable   = 1'b0;
   logic                pwrite    = 1'b0;
   logic [CSR_AW-1:0]   paddr     = '0;
   logic [PDATA_W-1:0]  pwdata    = '0;
   logic [PDATA_W-1:0]  prdata;
   logic                pready;

   int unsigned mismatches;
   int unsigned pending;

   // Knobs shared between the stimulus, the sender and the receiver, plus the watchdog count.
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_len       = 0;
   int unsigned idle_cycles    = 0;

   // Pool sizes as last written; only used to shape the stimulus.
   int unsigned pool_shadow [NUM_CFG] = '{1024, 1024, 1024};

   // Register settings per phase, extremes included: empty, single block,
   // full map and an over-range value that clamps to the full map.
   int unsigned phase_cfg   [NUM_PHASES][NUM_CFG] = '{
      '{16, 40, 1}, '{0, 2047, 5}, '{64, 3, 100}, '{1024, 2, 33}, '{24, 8, 12}};
   int unsigned phase_idle  [NUM_PHASES] = '{0, 63, 0, 10, 0};
   int unsigned phase_stall [NUM_PHASES] = '{0, 0, 63, 10, 0};

   always #5ns clock = ~clock;

   block_map_allocator_core #(
      .MAP_BLOCKS  (MAP_BLOCKS),
      .BLOCK_BYTES (BLOCK_BYTES),
      .POOLS       (POOLS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   block_map_allocator_checker #(
      .MAP_BLOCKS  (MAP_BLOCKS),
      .BLOCK_BYTES (BLOCK_BYTES),
      .POOLS       (POOLS)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .pready     (pready),
      .mismatches (mismatches),
      .pending    (pending)
   );

   // Watchdog: count cycles without any transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL block_map_allocator_core");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: drop ready at random; on request, hold it low for a long stretch
   // counted here, so the block fills up and stalls the request side.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_len != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_len) @(negedge clock);
            hold_len = 0;
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic req_type make_req(input logic [OP_W-1:0] op, input int unsigned pool,
                                        input int unsigned size, input int unsigned offset);
      req_type r;
      r.op          = op;
      r.pool        = POOL_W'(pool);
      r.size_bytes  = SIZE_W'(size);
      r.free_offset = FOFF_W'(offset);
      return r;
   endfunction

   // Mostly well-formed requests sized to the pool; some noise outside it.
   function automatic req_type random_request();
      req_type     r;
      int unsigned nblk, pick, need;
      r.size_bytes  = SIZE_W'($urandom);
      r.free_offset = FOFF_W'($urandom);
      r.pool        = ($urandom_range(99) < 6) ? POOL_W'(3) : POOL_W'($urandom_range(2));
      nblk = (r.pool < NUM_CFG) ? pool_shadow[r.pool] : 0;
      if (nblk > MAP_BLOCKS) nblk = MAP_BLOCKS;
      if (nblk == 0) nblk = 1;
      pick = $urandom_range(99);
      if (pick < 45) begin
         r.op = OP_ALLOC;
         case ($urandom_range(19))
            0:       r.size_bytes = '0;
            1:       ;  // keep the full-width random size
            default: begin
               need = $urandom_range((nblk / 3 > 1) ? nblk / 3 : 1, 1);
               r.size_bytes = SIZE_W'((need - 1) * BLOCK_BYTES + $urandom_range(BLOCK_BYTES, 1));
            end
         endcase
      end else if (pick < 80) begin
         r.op = OP_FREE;
         // mostly inside the pool, at any byte of a block
         if ($urandom_range(9) != 0)
            r.free_offset = FOFF_W'($urandom_range(nblk - 1) * BLOCK_BYTES
                                    + $urandom_range(BLOCK_BYTES - 1));
      end else if (pick < 95) begin
         r.op = OP_USAGE;
      end else begin
         r.op = OP_UNDEF;
      end
      return r;
   endfunction

   // Offer one request and hold it until the transfer; start and end at a falling edge.
   task automatic put_req(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Stop offering and wait until every predicted result has been taken.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // APB write: setup phase, then access phase, then idle before the next one.
   task automatic write_reg(input int unsigned idx, input int unsigned value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_AW'(idx * 4);
      pwdata  <= PDATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      pool_shadow[idx] = value;
      @(negedge clock);
   endtask

   initial begin
      // Hold reset, then release it at a falling edge.
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, registers at their reset values (1024 blocks each).
      put_req(make_req(OP_USAGE, 0, 0, 0));               // empty map
      put_req(make_req(OP_ALLOC, 0, 0, 0));               // zero size
      put_req(make_req(OP_ALLOC, 0, 4194303, 0));         // largest size, no fit
      put_req(make_req(OP_ALLOC, 2, 32768, 0));           // whole pool in one run
      put_req(make_req(OP_USAGE, 2, 0, 0));               // full pool
      put_req(make_req(OP_ALLOC, 2, 1, 0));               // full pool, no fit
      put_req(make_req(OP_FREE, 2, 0, 0));                // clear the whole pool
      put_req(make_req(OP_ALLOC, 0, 33, 0));              // rounds up to two blocks
      put_req(make_req(OP_ALLOC, 0, 32, 0));              // exactly one block
      put_req(make_req(OP_FREE, 0, 0, 32704 + 5));        // unaligned offset in a run
      put_req(make_req(OP_FREE, 0, 0, 32704));            // free of a free block
      put_req(make_req(OP_FREE, 0, 0, 65535));            // largest offset, out of range
      put_req(make_req(OP_FREE, 0, 0, 32768));            // first block past the pool
      put_req(make_req(OP_ALLOC, 3, 64, 0));              // pool with no map
      put_req(make_req(OP_FREE, 3, 0, 0));
      put_req(make_req(OP_USAGE, 3, 0, 0));
      put_req(make_req(OP_UNDEF, 3, 4194303, 65535));     // undefined op, all ones
      put_req(make_req(OP_ALLOC, 1, 3200, 0));            // 100 blocks at the top
      put_req(make_req(OP_FREE, 1, 0, 950 * BLOCK_BYTES)); // inside a run, clamped at end
      put_req(make_req(OP_USAGE, 1, 0, 0));
      put_req(make_req(OP_USAGE, 0, 0, 0));
      drain_results();

      // Random phases: new pool sizes while idle, then mostly well-formed traffic.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         for (int c = 0; c < NUM_CFG; c++) write_reg(c, phase_cfg[ph][c]);
         send_idle_pct  = phase_idle[ph];
         recv_stall_pct = phase_stall[ph];
         // last phase: long receiver hold-off while requests keep coming
         if (ph == NUM_PHASES - 1) hold_len = HOLD_CYCLES;
         for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // pause the sender once mid-phase until everything has come back
            if (ph == NUM_PHASES - 1 && n == RANDOM_ITEMS / 2) drain_results();
            put_req(random_request());
         end
         drain_results();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("PASS block_map_allocator_core");
      end else begin
         $display("FAIL block_map_allocator_core");
      end
      $finish;
   end

endmodule
